// ===== sv/assert_macros.svh =====
// Assertion helpers used by the top file to check the span setup block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Types and constants of the triangle scanline span setup block.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int COORD_FRAC = 8;
  localparam int GRAD_FRAC  = 16;
  localparam int MAX_ROWS   = 64;
  localparam int ROW_LIMIT  = 8192;
  localparam int CNT_W      = 7;
  localparam int QUOT_W     = 40;
  localparam int DIVSR_W    = 24;
  localparam int SPLIT      = 20;
  localparam logic [13:0] CFG_RESET = 14'd640;

  typedef struct packed {
    logic signed [23:0] vert0_x;
    logic signed [23:0] vert0_y;
    logic signed [23:0] vert1_x;
    logic signed [23:0] vert1_y;
    logic signed [23:0] vert2_x;
    logic signed [23:0] vert2_y;
    logic [12:0]        row_begin;
    logic [13:0]        row_end;
  } in_t;

  typedef struct packed {
    logic [12:0] row_index;
    logic [13:0] span_left;
    logic [13:0] span_right;
    logic        band_empty;
    logic        last_row;
  } out_t;

  typedef struct packed {
    logic [QUOT_W-1:0] grad_mag;
    logic              neg;
    logic              flat;
  } edge_t;

  typedef struct packed {
    logic signed [23:0] xa;
    logic signed [23:0] xb;
    logic signed [23:0] ya;
    logic signed [23:0] yb;
    edge_t              e01;
    edge_t              e12;
    edge_t              e02;
    logic               long_left;
    logic [12:0]        row_begin;
    logic [CNT_W-1:0]   nrows;
  } setup_t;

endpackage

// ===== sv/tss_fifo.sv =====
// ----------------------------------------------------------------------------
// tss_fifo
// Small register queue with a count; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module tss_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== sv/tss_divider.sv =====
// ----------------------------------------------------------------------------
// tss_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tss_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tss_pkg::QUOT_W-1:0]   dividend,
  input  logic [tss_pkg::DIVSR_W-1:0]  divisor,
  output logic                         busy,
  output logic [tss_pkg::QUOT_W-1:0]   quotient
);
  import tss_pkg::*;

  logic [DIVSR_W-1:0] dsr;
  logic [DIVSR_W-1:0] rem;
  logic [5:0]         cnt;
  logic [DIVSR_W:0]   trial;
  logic               fits;

  assign trial = {rem, quotient[QUOT_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= fits ? DIVSR_W'(trial - {1'b0, dsr}) : trial[DIVSR_W-1:0];
      quotient <= {quotient[QUOT_W-2:0], fits};
    end
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(QUOT_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end
endmodule

// ===== sv/tss_front.sv =====
// ----------------------------------------------------------------------------
// tss_front
// Takes a triangle, sorts its vertices by y, runs the three gradient
// divisions and writes one setup record to the queue.
// ----------------------------------------------------------------------------
module tss_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tss_pkg::in_t    in_item,
  output logic            full,
  output tss_pkg::setup_t setup,
  output logic            setup_push,
  input  logic            setup_full
);
  import tss_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_SORT = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [1:0]         idx;
  } vtx_t;

  fstate_t state;
  in_t     item;
  setup_t  rec;

  vtx_t s0, s1, s2, p0, p1, p2, q0, q1, t0, t1, t2;
  logic signed [24:0] dx01, dx12, dx02, dy01, dy12, dy02;
  logic [DIVSR_W-1:0] m01, m12, m02;
  logic        ll;
  logic [13:0] re_c;
  logic [13:0] span_c;
  logic [CNT_W-1:0] n_c;
  logic [QUOT_W-1:0] qt01, qt12, qt02;
  logic        b01, b12, b02;
  logic        start;

  function automatic logic [DIVSR_W-1:0] mag25(input logic signed [24:0] v);
    logic [24:0] m;
    m = v[24] ? 25'(-v) : 25'(v);
    return m[DIVSR_W-1:0];
  endfunction

  // Stable three-step sort network, swap only on strictly greater y.
  always_comb begin
    s0 = '{x: item.vert0_x, y: item.vert0_y, idx: 2'd0};
    s1 = '{x: item.vert1_x, y: item.vert1_y, idx: 2'd1};
    s2 = '{x: item.vert2_x, y: item.vert2_y, idx: 2'd2};
    if (s0.y > s1.y) begin
      p0 = s1; p1 = s0;
    end else begin
      p0 = s0; p1 = s1;
    end
    if (p1.y > s2.y) begin
      q1 = s2; p2 = p1;
    end else begin
      q1 = p1; p2 = s2;
    end
    if (p0.y > q1.y) begin
      q0 = q1; t1 = p0;
    end else begin
      q0 = p0; t1 = q1;
    end
    t0 = q0;
    t2 = p2;
    dx01 = 25'(t1.x) - 25'(t0.x);
    dx12 = 25'(t2.x) - 25'(t1.x);
    dx02 = 25'(t2.x) - 25'(t0.x);
    dy01 = 25'(t1.y) - 25'(t0.y);
    dy12 = 25'(t2.y) - 25'(t1.y);
    dy02 = 25'(t2.y) - 25'(t0.y);
    m01 = mag25(dx01);
    m12 = mag25(dx12);
    m02 = mag25(dx02);
    case (t0.idx)
      2'd0:    ll = (t2.idx == 2'd2);
      2'd1:    ll = (t2.idx == 2'd0);
      2'd2:    ll = (t2.idx == 2'd1);
      default: ll = 1'b0;
    endcase
    re_c   = (item.row_end > 14'(ROW_LIMIT)) ? 14'(ROW_LIMIT) : item.row_end;
    span_c = re_c - {1'b0, item.row_begin};
    if (re_c <= {1'b0, item.row_begin}) begin
      n_c = '0;
    end else if (span_c > 14'(MAX_ROWS)) begin
      n_c = CNT_W'(MAX_ROWS);
    end else begin
      n_c = span_c[CNT_W-1:0];
    end
  end

  assign start = (state == F_SORT);

  tss_divider u_div01 (
    .clk, .rst, .start,
    .dividend ({m01, GRAD_FRAC'(0)}), .divisor (dy01[DIVSR_W-1:0]),
    .busy (b01), .quotient (qt01)
  );
  tss_divider u_div12 (
    .clk, .rst, .start,
    .dividend ({m12, GRAD_FRAC'(0)}), .divisor (dy12[DIVSR_W-1:0]),
    .busy (b12), .quotient (qt12)
  );
  tss_divider u_div02 (
    .clk, .rst, .start,
    .dividend ({m02, GRAD_FRAC'(0)}), .divisor (dy02[DIVSR_W-1:0]),
    .busy (b02), .quotient (qt02)
  );

  assign full       = (state != F_IDLE);
  assign setup_push = (state == F_PUSH) && !setup_full;

  always_comb begin
    setup = rec;
    setup.e01.grad_mag = qt01;
    setup.e12.grad_mag = qt12;
    setup.e02.grad_mag = qt02;
  end

  always_ff @(posedge clk) begin
    if (push && state == F_IDLE) begin
      item <= in_item;
    end
    if (start) begin
      rec.xa        <= t0.x;
      rec.xb        <= t1.x;
      rec.ya        <= t0.y;
      rec.yb        <= t1.y;
      rec.e01       <= '{grad_mag: '0, neg: dx01[24], flat: (dy01 == '0)};
      rec.e12       <= '{grad_mag: '0, neg: dx12[24], flat: (dy12 == '0)};
      rec.e02       <= '{grad_mag: '0, neg: dx02[24], flat: (dy02 == '0)};
      rec.long_left <= ll;
      rec.row_begin <= item.row_begin;
      rec.nrows     <= n_c;
    end
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: if (push) state <= F_SORT;
        F_SORT: state <= F_DIV;
        F_DIV:  if (!b01 && !b12 && !b02) state <= F_PUSH;
        F_PUSH: if (!setup_full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/tss_back.sv =====
// ----------------------------------------------------------------------------
// tss_back
// Walks the rows of one setup record: offsets, edge products, edge x,
// then min/max, clamp and rounding. One row enters per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module tss_back (
  input  logic            clk,
  input  logic            rst,
  input  tss_pkg::setup_t setup,
  input  logic            setup_empty,
  output logic            setup_pop,
  input  logic [13:0]     canvas_width,
  output tss_pkg::out_t   res,
  output logic            res_push,
  input  logic            res_full
);
  import tss_pkg::*;

  typedef struct packed {
    logic [44:0] hi;
    logic [44:0] lo;
    logic [24:0] ao;
    logic        neg;
  } term_t;

  typedef struct packed {
    logic [12:0] row;
    logic        last;
    logic        emp;
  } tag_t;

  setup_t           rec;
  logic             active;
  logic [CNT_W-1:0] k;
  logic             en, issue, last_c;
  logic [12:0]      row_c;
  logic signed [25:0] yc, off0_c, off1_c;

  logic        v1, v2, v3, v4;
  tag_t        g1, g2, g3;
  logic [24:0] ao0, ao1;
  logic        on0, on1;
  term_t       t01, t12, t02;
  logic signed [48:0] x01, x12, x02;
  logic signed [48:0] lx, rx;

  function automatic logic signed [48:0] edge_x(input term_t t, input logic flat,
                                                input logic signed [23:0] xs);
    logic [65:0] p;
    logic [65:0] sat;
    logic [46:0] m;
    logic signed [48:0] term;
    sat = 66'(1) << 62;
    if (flat) begin
      p = (t.ao >= 25'd64) ? sat : (66'(t.ao) << 56);
    end else begin
      p = (66'(t.hi) << SPLIT) + 66'(t.lo);
    end
    if (p > sat) p = sat;
    if (t.neg) begin
      m = 47'((p + 66'((1 << GRAD_FRAC) - 1)) >> GRAD_FRAC);
      term = -$signed({2'b00, m});
    end else begin
      m = 47'(p >> GRAD_FRAC);
      term = $signed({2'b00, m});
    end
    return 49'(xs) + term;
  endfunction

  function automatic logic [13:0] to_col(input logic signed [48:0] x,
                                         input logic [13:0] cw);
    logic [21:0] hi;
    logic [21:0] v;
    logic [22:0] r;
    hi = {cw, 8'h00};
    if (x[48]) begin
      v = '0;
    end else if (x[47:0] > 48'(hi)) begin
      v = hi;
    end else begin
      v = x[21:0];
    end
    r = 23'(v) + 23'(1 << (COORD_FRAC - 1));
    return r[21:8];
  endfunction

  function automatic term_t mk_term(input edge_t e, input logic [24:0] ao,
                                    input logic on);
    term_t t;
    t.hi  = e.grad_mag[QUOT_W-1:SPLIT] * ao;
    t.lo  = e.grad_mag[SPLIT-1:0] * ao;
    t.ao  = ao;
    t.neg = e.neg != on;
    return t;
  endfunction

  // Stall every stage together when the finished row cannot leave.
  assign en        = !(v4 && res_full);
  assign res_push  = v4 && !res_full;
  assign setup_pop = !active && !setup_empty && !v1 && !v2 && !v3 && !v4;
  assign issue     = active && en;
  assign row_c     = rec.row_begin + 13'(k);
  assign last_c    = (rec.nrows == '0) || (k == rec.nrows - 1'b1);
  assign yc        = $signed({5'b0, row_c, 8'h80});
  assign off0_c    = yc - 26'(rec.ya);
  assign off1_c    = yc - 26'(rec.yb);

  always_comb begin
    if (rec.long_left) begin
      lx = x02;
      rx = (x01 < x12) ? x01 : x12;
    end else begin
      lx = (x01 > x12) ? x01 : x12;
      rx = x02;
    end
  end

  always_ff @(posedge clk) begin
    if (setup_pop) begin
      rec <= setup;
    end
    if (en) begin
      g1  <= '{row: row_c, last: last_c, emp: (rec.nrows == '0)};
      ao0 <= off0_c[25] ? 25'(-off0_c) : 25'(off0_c);
      ao1 <= off1_c[25] ? 25'(-off1_c) : 25'(off1_c);
      on0 <= off0_c[25];
      on1 <= off1_c[25];
      g2  <= g1;
      t01 <= mk_term(rec.e01, ao0, on0);
      t12 <= mk_term(rec.e12, ao1, on1);
      t02 <= mk_term(rec.e02, ao0, on0);
      g3  <= g2;
      x01 <= edge_x(t01, rec.e01.flat, rec.xa);
      x12 <= edge_x(t12, rec.e12.flat, rec.xb);
      x02 <= edge_x(t02, rec.e02.flat, rec.xa);
      res.row_index  <= g3.row;
      res.span_left  <= g3.emp ? 14'd0 : to_col(lx, canvas_width);
      res.span_right <= g3.emp ? 14'd0 : to_col(rx, canvas_width);
      res.band_empty <= g3.emp;
      res.last_row   <= g3.last;
    end
    if (rst) begin
      active <= 1'b0;
      k      <= '0;
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      v4     <= 1'b0;
    end else begin
      if (setup_pop) begin
        active <= 1'b1;
        k      <= '0;
      end else if (issue) begin
        k <= k + 1'b1;
        if (last_c) active <= 1'b0;
      end
      if (en) begin
        v1 <= issue;
        v2 <= v1;
        v3 <= v2;
        v4 <= v3;
      end
    end
  end
endmodule

// ===== sv/triangle_scanline_span_setup_top.sv =====
// ----------------------------------------------------------------------------
// triangle_scanline_span_setup_top
// Triangle edge walker: per row of a band, left and right span bounds.
// ----------------------------------------------------------------------------
// A triangle is taken when full is low; full stays high while its setup runs:
// it is sorted, the three gradient divisions run (three bit-serial dividers
// side by side), the record is queued, waiting while the setup queue is full,
// and the front returns to idle, so no new triangle enters until then. The row
// walker then gives one result per cycle while the result queue has room, 64 at
// most per triangle, and drains its four-stage pipeline before starting the
// next record. An empty band gives one flagged result. Write canvas_width only
// while the block is idle.
module triangle_scanline_span_setup_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tss_pkg::in_t  in_item,
  output logic          full,
  output logic          empty,
  input  logic          pop,
  output tss_pkg::out_t out_item,
  input  logic          cfg_wr_en,
  input  logic [13:0]   cfg_wr_data
);
  import tss_pkg::*;

  logic [13:0] canvas_width;
  setup_t      sq_wdata, sq_rdata;
  logic        sq_push, sq_full, sq_pop, sq_empty;
  out_t        res;
  logic        res_push, res_full;
  logic [$bits(out_t)-1:0] oq_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width <= CFG_RESET;
    end else if (cfg_wr_en) begin
      canvas_width <= cfg_wr_data;
    end
  end

  tss_front u_front (
    .clk, .rst, .push, .in_item, .full,
    .setup (sq_wdata), .setup_push (sq_push), .setup_full (sq_full)
  );

  tss_fifo #(.WIDTH($bits(setup_t)), .DEPTH(2)) u_setup_q (
    .clk, .rst, .wr (sq_push), .wdata (sq_wdata), .full (sq_full),
    .rd (sq_pop), .rdata (sq_rdata), .empty (sq_empty)
  );

  tss_back u_back (
    .clk, .rst, .setup (sq_rdata), .setup_empty (sq_empty), .setup_pop (sq_pop),
    .canvas_width, .res, .res_push, .res_full
  );

  tss_fifo #(.WIDTH($bits(out_t)), .DEPTH(4)) u_result_q (
    .clk, .rst, .wr (res_push), .wdata (res), .full (res_full),
    .rd (pop), .rdata (oq_rdata), .empty
  );

  assign out_item = out_t'(oq_rdata);

`include "assert_macros.svh"

  `ASSERT_NEVER(a_sq_overrun, sq_push && sq_full, "setup record written into a full queue")
  `ASSERT_CLK(a_empty_is_last, !empty && out_item.band_empty |-> out_item.last_row, "empty band result not last")
  `ASSERT_CLK(a_empty_zero, !empty && out_item.band_empty |-> out_item.span_left == 14'd0 && out_item.span_right == 14'd0, "empty band with bounds")
  `ASSERT_NEVER(a_pop_busy, sq_pop && !sq_empty && res_push, "record taken while rows in flight")

endmodule
